>>> hdl/b2s_pkg.sv
// shared types, constants and tables of the blake2s keyed hash unit
// no dependencies; imported by every module of the block
package b2s_pkg;

    localparam int BLOCK_BYTES      = 64;
    localparam int MAX_DIGEST_BYTES = 32;
    localparam int ROUND_COUNT      = 10;
    localparam logic [31:0] FINAL_FLAG = 32'hFFFFFFFF;

    localparam logic [31:0] IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    typedef enum logic [2:0] {
        C_IDLE, C_G, C_DIAG, C_UNDIAG, C_FIN
    } b2s_cstate_t;

    typedef enum logic [2:0] {
        T_IDLE, T_PREP, T_CWAIT, T_FSTART, T_FWAIT, T_OUT
    } b2s_tstate_t;

    typedef struct packed {
        logic start;
        logic last_blk;
    } b2s_cmd_t;

endpackage

>>> hdl/b2s_half_g.sv
// one half of the blake2s mixing function, the shared arithmetic unit
// depends on b2s_pkg
module b2s_half_g
    import b2s_pkg::*;
(
    input  logic [31:0] a_in,
    input  logic [31:0] b_in,
    input  logic [31:0] c_in,
    input  logic [31:0] d_in,
    input  logic [31:0] msg_in,
    input  logic        second,
    output logic [31:0] a_out,
    output logic [31:0] b_out,
    output logic [31:0] c_out,
    output logic [31:0] d_out
);
    logic [31:0] dx;
    logic [31:0] bx;

    always_comb begin
        a_out = a_in + b_in + msg_in;
        dx    = d_in ^ a_out;
        d_out = second ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
        c_out = c_in + d_out;
        bx    = b_in ^ c_out;
        b_out = second ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
    end
endmodule

>>> hdl/b2s_core.sv
// compression sequencer: work vector, round counter, one shared half-g unit
// depends on b2s_pkg and b2s_half_g
module b2s_core
    import b2s_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  b2s_cmd_t         cmd,
    input  logic [63:0]      count_in,
    input  logic [7:0][31:0] h_in,
    input  logic [31:0]      msg_word,
    output logic [3:0]       msg_idx,
    output logic [7:0][31:0] h_out,
    output logic             done
);
    b2s_cstate_t phase_reg, phase_next;
    logic [3:0]  round_reg;
    logic [2:0]  g_reg;
    logic        half_reg;
    logic [31:0] v_reg [16];
    logic [31:0] t_vec [16];
    logic [31:0] na, nb, nc, nd;

    b2s_half_g u_g (
        .a_in(v_reg[0]), .b_in(v_reg[4]), .c_in(v_reg[8]), .d_in(v_reg[12]),
        .msg_in(msg_word), .second(half_reg),
        .a_out(na), .b_out(nb), .c_out(nc), .d_out(nd)
    );

    // column zero of each row takes the mixed values
    always_comb begin
        for (int i = 0; i < 16; i++) t_vec[i] = v_reg[i];
        t_vec[0]  = na;
        t_vec[4]  = nb;
        t_vec[8]  = nc;
        t_vec[12] = nd;
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            C_IDLE:   if (cmd.start) phase_next = C_G;
            C_G: begin
                if (half_reg && g_reg == 3'd3) phase_next = C_DIAG;
                else if (half_reg && g_reg == 3'd7) phase_next = C_UNDIAG;
            end
            C_DIAG:   phase_next = C_G;
            C_UNDIAG: phase_next = (round_reg == 4'(ROUND_COUNT - 1)) ? C_FIN : C_G;
            C_FIN:    phase_next = C_IDLE;
            default:  phase_next = C_IDLE;
        endcase
    end

    always_comb begin
        done    = (phase_reg == C_FIN);
        msg_idx = SIGMA[round_reg][{g_reg, half_reg}];
        for (int i = 0; i < 8; i++) h_out[i] = h_in[i] ^ v_reg[i] ^ v_reg[i + 8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= C_IDLE;
            round_reg <= '0;
            g_reg     <= '0;
            half_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            case (phase_reg)
                C_IDLE: begin
                    round_reg <= '0;
                    g_reg     <= '0;
                    half_reg  <= 1'b0;
                end
                C_G: begin
                    half_reg <= ~half_reg;
                    if (half_reg) g_reg <= g_reg + 3'd1;
                end
                C_UNDIAG: begin
                    if (round_reg != 4'(ROUND_COUNT - 1)) round_reg <= round_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    // work vector held as four rows of four; the unit always mixes column zero
    always_ff @(posedge aclk) begin
        case (phase_reg)
            C_IDLE: begin
                if (cmd.start) begin
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_in[i];
                    for (int i = 0; i < 4; i++) v_reg[i + 8] <= IV[i];
                    v_reg[12] <= IV[4] ^ count_in[31:0];
                    v_reg[13] <= IV[5] ^ count_in[63:32];
                    v_reg[14] <= IV[6] ^ (cmd.last_blk ? FINAL_FLAG : 32'h0);
                    v_reg[15] <= IV[7];
                end
            end
            C_G: begin
                for (int r = 0; r < 4; r++)
                    for (int i = 0; i < 4; i++)
                        v_reg[4*r+i] <= half_reg ? t_vec[4*r+((i+1)%4)] : t_vec[4*r+i];
            end
            C_DIAG: begin
                for (int r = 0; r < 4; r++)
                    for (int i = 0; i < 4; i++)
                        v_reg[4*r+i] <= v_reg[4*r+((i+r)%4)];
            end
            C_UNDIAG: begin
                for (int r = 0; r < 4; r++)
                    for (int i = 0; i < 4; i++)
                        v_reg[4*r+i] <= v_reg[4*r+((i+4-r)%4)];
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> phase_reg == C_IDLE) else $error("start while busy");
    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> phase_reg == C_G && round_reg == 4'd0 && g_reg == 3'd0)
        else $error("compression did not begin");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done longer than one cycle");
    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg < 4'(ROUND_COUNT)) else $error("round counter overrun");
`endif
endmodule

>>> hdl/blake2s_keyed_hash_unit.sv
// top level of the blake2s keyed hash unit: config registers, chaining
// value, byte counter, block buffer and message control; uses b2s_pkg, b2s_core
//
// Usage: a message arrives as 32-bit little-endian words, four bytes each
// except the last, which carries 0 to 4 bytes (0 only for an empty message).
// A word that lands in the block buffer is accepted, then stored; the
// first word of a message first sets up the chaining value and key
// block. A word that arrives while the buffer holds a full block waits for one
// compression: 10 rounds on the single shared half-g unit plus a start and
// a finish step. After the last word the final block is compressed the same
// way and the digest goes out one word a cycle while m_tready is high, up
// to 8.
// Config writes take effect at the next message's first word, except that
// the digest size register sets the output word count at finalization.
module blake2s_keyed_hash_unit
    import b2s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wr_data,
    // message words in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] message_word, [34:32] valid_bytes
    input  logic        s_tlast,   // last_word
    // digest words out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] digest_bytes
    output logic        m_tlast    // last_result
);
    localparam logic [2:0] REG_DIGEST_LEN = 3'd0;
    localparam logic [2:0] REG_KEY_LEN    = 3'd1;
    localparam logic [2:0] REG_KEY_0      = 3'd2;
    localparam logic [2:0] REG_KEY_1      = 3'd3;
    localparam logic [2:0] REG_KEY_2      = 3'd4;
    localparam logic [2:0] REG_KEY_3      = 3'd5;

    // configuration
    logic [5:0]   dig_len_reg;
    logic [5:0]   key_len_reg;
    logic [255:0] key_reg;

    // hash state
    b2s_tstate_t      state_reg, state_next;
    logic [7:0][31:0] chain_reg;
    logic [63:0]      count_reg;
    logic [31:0]      buf_reg [16];
    logic [6:0]       fill_reg;
    logic             open_reg;
    logic [2:0]       k_reg;

    // captured input word
    logic [31:0] word_reg;
    logic [2:0]  n_reg;
    logic        last_reg;

    // core link
    b2s_cmd_t         cmd;
    logic [63:0]      core_count;
    logic [3:0]       msg_idx;
    logic [7:0][31:0] core_h;
    logic             core_done;

    // derived values
    logic [5:0]  dl_eff;
    logic [5:0]  kl_eff;
    logic [2:0]  in_n;
    logic [31:0] word_masked;
    logic [31:0] key_blk [16];
    logic [31:0] param_word;
    logic        need_comp;
    logic [5:0]  rem_bytes;
    logic [2:0]  out_nb;
    logic [31:0] out_word;
    logic        out_last;

    b2s_core u_core (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .count_in(core_count),
        .h_in(chain_reg), .msg_word(buf_reg[msg_idx]), .msg_idx(msg_idx),
        .h_out(core_h), .done(core_done)
    );

    // saturated lengths
    always_comb begin
        dl_eff = (dig_len_reg > 6'(MAX_DIGEST_BYTES)) ? 6'(MAX_DIGEST_BYTES) : dig_len_reg;
        if (dl_eff == 6'd0) dl_eff = 6'd1;
        kl_eff = (key_len_reg > 6'd32) ? 6'd32 : key_len_reg;
        param_word = {24'h010100, 8'h00} | {26'h0, dl_eff} | {18'h0, kl_eff, 8'h00};
    end

    // byte count of an incoming word, last word saturates at four
    always_comb begin
        if (s_tlast) in_n = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
        else         in_n = 3'd4;
    end

    always_comb begin
        case (n_reg)
            3'd1:    word_masked = {24'h0, word_reg[7:0]};
            3'd2:    word_masked = {16'h0, word_reg[15:0]};
            3'd3:    word_masked = {8'h0, word_reg[23:0]};
            default: word_masked = word_reg;
        endcase
    end

    // key block, bytes past the key length are zero
    always_comb begin
        for (int w = 0; w < 16; w++) begin
            for (int j = 0; j < 4; j++) begin
                if (w < 8 && 6'(4*w+j) < kl_eff)
                    key_blk[w][8*j +: 8] = key_reg[32*(w%8)+8*j +: 8];
                else
                    key_blk[w][8*j +: 8] = 8'h00;
            end
        end
    end

    // full buffer is compressed only when more bytes show up
    assign need_comp  = open_reg && (n_reg != 3'd0) && fill_reg[6];
    assign core_count = (state_reg == T_FSTART) ? count_reg + {57'h0, fill_reg}
                                                 : count_reg + 64'(BLOCK_BYTES);

    // digest word selection
    always_comb begin
        rem_bytes = dl_eff - {1'b0, k_reg, 2'b00};
        out_nb    = (rem_bytes >= 6'd4) ? 3'd4 : rem_bytes[2:0];
        out_last  = (rem_bytes <= 6'd4);
        case (out_nb)
            3'd1:    out_word = {24'h0, chain_reg[k_reg][7:0]};
            3'd2:    out_word = {16'h0, chain_reg[k_reg][15:0]};
            3'd3:    out_word = {8'h0, chain_reg[k_reg][23:0]};
            default: out_word = chain_reg[k_reg];
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:   if (s_tvalid) state_next = T_PREP;
            T_PREP: begin
                if (open_reg) begin
                    if (need_comp)     state_next = T_CWAIT;
                    else if (last_reg) state_next = T_FSTART;
                    else               state_next = T_IDLE;
                end
            end
            T_CWAIT:  if (core_done) state_next = T_PREP;
            T_FSTART: state_next = T_FWAIT;
            T_FWAIT:  if (core_done) state_next = T_OUT;
            T_OUT:    if (m_tready && out_last) state_next = T_IDLE;
            default:  state_next = T_IDLE;
        endcase
    end

    // handshake and core command
    always_comb begin
        s_tready     = (state_reg == T_IDLE);
        m_tvalid     = (state_reg == T_OUT);
        m_tdata      = {5'h0, out_nb, out_word};
        m_tlast      = out_last;
        cmd.start    = (state_reg == T_FSTART) || (state_reg == T_PREP && need_comp);
        cmd.last_blk = (state_reg == T_FSTART);
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dig_len_reg <= 6'(MAX_DIGEST_BYTES);
            key_len_reg <= '0;
            key_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DIGEST_LEN: dig_len_reg       <= cfg_wr_data[5:0];
                REG_KEY_LEN:    key_len_reg       <= cfg_wr_data[5:0];
                REG_KEY_0:      key_reg[63:0]     <= cfg_wr_data;
                REG_KEY_1:      key_reg[127:64]   <= cfg_wr_data;
                REG_KEY_2:      key_reg[191:128]  <= cfg_wr_data;
                REG_KEY_3:      key_reg[255:192]  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            open_reg  <= 1'b0;
            fill_reg  <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                T_PREP: begin
                    if (!open_reg) begin
                        open_reg <= 1'b1;
                        fill_reg <= (kl_eff != 6'd0) ? 7'(BLOCK_BYTES) : 7'd0;
                    end else if (!need_comp) begin
                        fill_reg <= fill_reg + {4'h0, n_reg};
                    end
                end
                T_CWAIT: if (core_done) fill_reg <= '0;
                T_FWAIT: k_reg <= '0;
                T_OUT: begin
                    if (m_tready) begin
                        k_reg <= k_reg + 3'd1;
                        if (out_last) open_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload: input capture, chaining value, counter, block buffer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg <= s_tdata[31:0];
            n_reg    <= in_n;
            last_reg <= s_tlast;
        end
        case (state_reg)
            T_PREP: begin
                if (!open_reg) begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= (i == 0) ? IV[0] ^ param_word : IV[i];
                    count_reg    <= '0;
                    for (int i = 0; i < 16; i++) buf_reg[i] <= key_blk[i];
                end else if (need_comp) begin
                    count_reg <= core_count;
                end else if (n_reg != 3'd0) begin
                    buf_reg[fill_reg[5:2]] <= word_masked;
                end
            end
            T_CWAIT: begin
                if (core_done) begin
                    chain_reg <= core_h;
                    for (int i = 0; i < 16; i++) buf_reg[i] <= '0;
                end
            end
            T_FSTART: count_reg <= core_count;
            T_FWAIT:  if (core_done) chain_reg <= core_h;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output open together");
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 7'(BLOCK_BYTES)) else $error("buffer fill overrun");
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !open_reg)
        else $error("message not closed after last digest word");
    a_no_store_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == T_PREP && open_reg && n_reg != 3'd0 && fill_reg[6] |-> cmd.start)
        else $error("word stored into a full buffer");
`endif
endmodule

>>> verif/tb_blake2s_keyed_hash_unit.sv
// self-checking testbench of blake2s_keyed_hash_unit: directed and random messages
// checked against an in-bench blake2s predictor; depends on b2s_pkg and the rtl
module tb_blake2s_keyed_hash_unit
    import b2s_pkg::*;
();

    localparam int DRAIN_CYCLES = 250;   // about one compression plus margin
    localparam int STALL_LIMIT  = 20000; // cycles with no word moving on either side

    // config register indexes
    localparam logic [2:0] REG_DIGEST_LEN = 3'd0;
    localparam logic [2:0] REG_KEY_LEN    = 3'd1;
    localparam logic [2:0] REG_KEY_0      = 3'd2;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [63:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    blake2s_keyed_hash_unit dut (.*);

    always #5 aclk = ~aclk;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } digest_word_t;

    digest_word_t digest_q[$];
    int errors = 0;
    int idle_pct = 0;   // sender gap chance per cycle
    int stall_pct = 0;  // receiver stall chance per cycle
    int words_sent = 0;

    // predictor copy of config and hash state
    logic [5:0]  pr_dlen = 6'd32;
    logic [5:0]  pr_klen = 6'd0;
    logic [63:0] pr_key [4] = '{default: '0};
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [31:0] wv [16];
    logic [63:0] nbytes_seen;
    int          fill;
    bit          in_msg = 1'b0;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void g_mix(int a, int b, int c, int d, logic [31:0] x, logic [31:0] y);
        wv[a] = wv[a] + wv[b] + x;
        wv[d] = rotr(wv[d] ^ wv[a], 16);
        wv[c] = wv[c] + wv[d];
        wv[b] = rotr(wv[b] ^ wv[c], 12);
        wv[a] = wv[a] + wv[b] + y;
        wv[d] = rotr(wv[d] ^ wv[a], 8);
        wv[c] = wv[c] + wv[d];
        wv[b] = rotr(wv[b] ^ wv[c], 7);
    endfunction

    function automatic void compress_block(bit fin);
        for (int i = 0; i < 8; i++) begin
            wv[i] = chain[i];
            wv[i+8] = IV[i];
        end
        wv[12] ^= nbytes_seen[31:0];
        wv[13] ^= nbytes_seen[63:32];
        if (fin) wv[14] ^= FINAL_FLAG;
        for (int r = 0; r < ROUND_COUNT; r++) begin
            g_mix(0, 4, 8, 12, blk[SIGMA[r][0]], blk[SIGMA[r][1]]);
            g_mix(1, 5, 9, 13, blk[SIGMA[r][2]], blk[SIGMA[r][3]]);
            g_mix(2, 6, 10, 14, blk[SIGMA[r][4]], blk[SIGMA[r][5]]);
            g_mix(3, 7, 11, 15, blk[SIGMA[r][6]], blk[SIGMA[r][7]]);
            g_mix(0, 5, 10, 15, blk[SIGMA[r][8]], blk[SIGMA[r][9]]);
            g_mix(1, 6, 11, 12, blk[SIGMA[r][10]], blk[SIGMA[r][11]]);
            g_mix(2, 7, 8, 13, blk[SIGMA[r][12]], blk[SIGMA[r][13]]);
            g_mix(3, 4, 9, 14, blk[SIGMA[r][14]], blk[SIGMA[r][15]]);
        end
        for (int i = 0; i < 8; i++) chain[i] ^= wv[i] ^ wv[i+8];
    endfunction

    function automatic int eff_dlen();
        if (pr_dlen > MAX_DIGEST_BYTES) return MAX_DIGEST_BYTES;
        if (pr_dlen == 0) return 1;
        return pr_dlen;
    endfunction

    function automatic void open_msg();
        int kl;
        logic [7:0] kb;
        kl = (pr_klen > 32) ? 32 : pr_klen;
        foreach (chain[i]) chain[i] = IV[i];
        chain[0] ^= eff_dlen() | (kl << 8) | (1 << 16) | (1 << 24);
        nbytes_seen = '0;
        foreach (blk[i]) blk[i] = '0;
        fill = 0;
        for (int i = 0; i < kl; i++) begin
            kb = pr_key[i/8][8*(i%8) +: 8];
            blk[i/4][8*(i%4) +: 8] = kb;
        end
        if (kl > 0) fill = BLOCK_BYTES;
        in_msg = 1'b1;
    endfunction

    // advance the hash by one accepted word; queue digest words on the last one
    function automatic void predict_word(logic [31:0] w, logic [2:0] vb, logic lst);
        int n, dl, cnt, nb;
        digest_word_t d;
        n = lst ? ((vb > 4) ? 4 : vb) : 4;
        if (!in_msg) open_msg();
        if (n > 0) begin
            if (fill >= BLOCK_BYTES) begin
                nbytes_seen += BLOCK_BYTES;
                compress_block(1'b0);
                foreach (blk[i]) blk[i] = '0;
                fill = 0;
            end
            if (n < 4) w &= (32'h1 << (8 * n)) - 1;
            blk[fill/4] = w;
            fill += n;
        end
        if (!lst) return;
        nbytes_seen += fill;
        compress_block(1'b1);
        dl = eff_dlen();
        cnt = (dl + 3) / 4;
        for (int k = 0; k < cnt; k++) begin
            nb = dl - 4 * k;
            if (nb > 4) nb = 4;
            d.word = chain[k];
            if (nb < 4) d.word &= (32'h1 << (8 * nb)) - 1;
            d.nbytes = 3'(nb);
            d.last = (k + 1 == cnt);
            digest_q.push_back(d);
        end
        in_msg = 1'b0;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one config write per cycle; predictor follows
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        if (idx == REG_DIGEST_LEN) pr_dlen = val[5:0];
        else if (idx == REG_KEY_LEN) pr_klen = val[5:0];
        else pr_key[idx - REG_KEY_0] = val;
    endtask

    task automatic set_config(logic [5:0] dl, logic [5:0] kl, bit ones_key);
        write_reg(REG_DIGEST_LEN, {58'd0, dl});
        write_reg(REG_KEY_LEN, {58'd0, kl});
        for (int i = 0; i < 4; i++)
            write_reg(3'(REG_KEY_0 + i), ones_key ? '1 : {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
    endtask

    // wait for every digest word, then for the block to go quiet
    task automatic drain();
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // present one word, with random gaps ahead of it, until it is taken
    task automatic push_word(logic [31:0] w, logic [2:0] vb, logic lst);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, vb, w};
        s_tlast <= lst;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        predict_word(w, vb, lst);
        words_sent++;
    endtask

    // non-last words get random valid_bytes, which the block must ignore
    task automatic send_msg(int nwords, logic [2:0] last_vb);
        for (int i = 0; i < nwords; i++)
            push_word($urandom, (i == nwords - 1) ? last_vb : 3'($urandom_range(7)),
                      i == nwords - 1);
        s_tvalid <= 1'b0;
    endtask

    typedef struct {
        logic [5:0] dl;
        logic [5:0] kl;
        bit         ones_key;
        int         nwords;
        logic [2:0] last_vb;
    } msg_row_t;

    // directed messages; digests come from the predictor
    msg_row_t directed [7] = '{
        '{6'd32, 6'd0,  1'b0, 1,  3'd0},  // empty unkeyed message
        '{6'd1,  6'd32, 1'b1, 1,  3'd3},  // shortest digest, full all-ones key
        '{6'd0,  6'd0,  1'b0, 2,  3'd0},  // zero digest length, empty last word
        '{6'd63, 6'd63, 1'b0, 1,  3'd7},  // oversized lengths and byte count
        '{6'd17, 6'd5,  1'b0, 1,  3'd0},  // keyed empty message
        '{6'd32, 6'd0,  1'b0, 17, 3'd4},  // crosses a block boundary
        '{6'd31, 6'd1,  1'b0, 1,  3'd1}   // one key byte, one message byte
    };

    // receiver: random stalls per cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // digest word checker
    always @(posedge aclk) begin
        digest_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], '0);
            end else begin
                want = digest_q.pop_front();
                if (m_tdata[31:0] !== want.word)
                    report_mismatch("digest_word", m_tdata[31:0], want.word);
                if (m_tdata[34:32] !== want.nbytes)
                    report_mismatch("digest_bytes", 32'(m_tdata[34:32]), 32'(want.nbytes));
                if (m_tlast !== want.last)
                    report_mismatch("last_result", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // watchdog on cycles where no word moves
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("tb_blake2s_keyed_hash_unit: FAIL");
                $finish;
            end
        end
    end

    int phase_idle [4] = '{0, 73, 0, 38};
    int phase_stall [4] = '{0, 0, 73, 38};
    logic [5:0] dl_pick [6] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd16, 6'd7};

    initial begin
        int nw, target;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed part
        foreach (directed[r]) begin
            set_config(directed[r].dl, directed[r].kl, directed[r].ones_key);
            send_msg(directed[r].nwords, directed[r].last_vb);
            drain();
        end

        // random part, one phase per idling mode
        target = words_sent;
        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            target += 18;
            while (words_sent < target) begin
                set_config($urandom_range(3) == 0 ? dl_pick[$urandom_range(5)]
                                                  : 6'($urandom_range(1, 32)),
                           $urandom_range(4) == 0 ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(32)),
                           1'b0);
                // mostly short messages, now and then a longer one that may run past a block
                nw = ($urandom_range(5) == 0) ? $urandom_range(15, 33) : $urandom_range(1, 6);
                send_msg(nw, 3'($urandom_range(7)));
                drain();
            end
        end

        if (errors == 0) begin
            $display("tb_blake2s_keyed_hash_unit: PASS");
        end else begin
            $display("tb_blake2s_keyed_hash_unit: FAIL");
        end
        $finish;
    end

endmodule
